// ----- sv/dvrt_pkg.sv -----
// Package for the distance-vector route table: kinds, widths, defaults, request record and states.
// Used by every module of the block; depends on nothing.
package dvrt_pkg;

    localparam int NODE_COUNT_DEFAULT = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELOAD    = 2'd2;

    localparam logic [3:0] OWN_NODE_RESET  = 4'd3;
    localparam logic [7:0] THRESHOLD_RESET = 8'd200;
    localparam logic [3:0] RELOAD_RESET    = 4'd5;
    localparam logic [3:0] COST_MAX        = 4'hF;

    typedef enum logic [2:0] {
        KIND_BEACON  = 3'd0,
        KIND_HEADER  = 3'd1,
        KIND_ENTRY   = 3'd2,
        KIND_TICK    = 3'd3,
        KIND_ADVERT  = 3'd4,
        KIND_LOOKUP  = 3'd5,
        KIND_RSVD6   = 3'd6,
        KIND_RSVD7   = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        OUT_BEACON = 2'd0,
        OUT_HEADER = 2'd1,
        OUT_ENTRY  = 2'd2,
        OUT_LOOKUP = 2'd3
    } out_kind_t;

    // One classified request travelling from the front part to the back part.
    typedef struct packed {
        kind_t      kind;
        logic [3:0] node_id;
        logic [7:0] sequence_req;
        logic       strength_ok;
        logic [3:0] entry_dest;
        logic [3:0] entry_cost;
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TICK,
        ST_ADV,
        ST_LOOKUP
    } state_t;

endpackage

// ----- sv/distance_vector_route_table.sv -----
// Each request is queued, taken into the back part's request register once that part is idle,
// and carried out in the EXEC state; lookups go on to LOOKUP, ticks walk each neighbour
// in TICK and adverts give one entry per nonzero route in ADV. Throughput: one request at
// a time; a two-entry queue holds later requests and busy is high while it is full. Results
// last one cycle with done high and the receiver cannot stall. Reset (rst_n low,
// asynchronous) clears all tables; uses dvrt_pkg.
module distance_vector_route_table
    import dvrt_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [2:0]            kind,
    input  logic [3:0]            node_id,
    input  logic [7:0]            sequence_req,
    input  logic [7:0]            signal_strength,
    input  logic [3:0]            entry_dest,
    input  logic [3:0]            entry_cost,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output logic [1:0]            out_kind,
    output logic [7:0]            sequence_out,
    output logic [3:0]            dest_out,
    output logic [3:0]            cost_out,
    output logic [3:0]            next_hop,
    output logic                  found,
    output logic                  last
);
    logic [3:0] own_node_reg, reload_reg;
    logic [7:0] threshold_reg;
    logic       q_valid, q_pop;
    req_t       q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_node_reg <= OWN_NODE_RESET;
            threshold_reg <= THRESHOLD_RESET;
            reload_reg <= RELOAD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OWN_NODE:  own_node_reg <= cfg_data[3:0];
                CFG_THRESHOLD: threshold_reg <= cfg_data;
                CFG_RELOAD:    reload_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    dvrt_front u_front (
        .clk, .rst_n, .start, .busy, .kind, .node_id, .sequence_req,
        .signal_strength, .entry_dest, .entry_cost,
        .threshold(threshold_reg), .q_valid, .q_data, .q_pop
    );

    dvrt_back #(.NODE_COUNT(NODE_COUNT)) u_back (
        .clk, .rst_n, .q_valid, .q_data, .q_pop,
        .own_node(own_node_reg), .reload(reload_reg),
        .done, .out_kind, .sequence_out, .dest_out, .cost_out,
        .next_hop, .found, .last
    );
endmodule

// ----- sv/dvrt_front.sv -----
// Front part: takes requests, prechecks signal strength, and queues them.
// Depends on dvrt_pkg.
module dvrt_front
    import dvrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] kind,
    input  logic [3:0] node_id,
    input  logic [7:0] sequence_req,
    input  logic [7:0] signal_strength,
    input  logic [3:0] entry_dest,
    input  logic [3:0] entry_cost,
    input  logic [7:0] threshold,
    output logic       q_valid,
    output req_t       q_data,
    input  logic       q_pop
);
    // Two-entry queue; the block reports busy when it is full.
    req_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    req_t       req_in;

    assign busy = (cnt_reg == 2'd2);
    assign push = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        req_in.kind = kind_t'(kind);
        req_in.node_id = node_id;
        req_in.sequence_req = sequence_req;
        req_in.strength_ok = signal_strength > threshold;
        req_in.entry_dest = entry_dest;
        req_in.entry_cost = entry_cost;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= req_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

// ----- sv/dvrt_back.sv -----
// Back part: holds the neighbour and route tables and carries out each request.
// Depends on dvrt_pkg.
module dvrt_back
    import dvrt_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  req_t       q_data,
    output logic       q_pop,
    input  logic [3:0] own_node,
    input  logic [3:0] reload,
    output logic       done,
    output logic [1:0] out_kind,
    output logic [7:0] sequence_out,
    output logic [3:0] dest_out,
    output logic [3:0] cost_out,
    output logic [3:0] next_hop,
    output logic       found,
    output logic       last
);
    localparam int IW = $clog2(NODE_COUNT);
    localparam int CELLS = NODE_COUNT * NODE_COUNT;
    localparam int CW = $clog2(CELLS);
    localparam logic [3:0] NMAX = 4'(NODE_COUNT);

    state_t state_reg, state_next;
    req_t   cur_reg;
    logic [3:0] live_reg [NODE_COUNT];
    logic [7:0] seen_reg [NODE_COUNT];
    logic [3:0] cost_reg [CELLS];
    logic [7:0] own_seq_reg;
    logic       hdr_ok_reg;
    logic [3:0] hdr_snd_reg;
    logic [CW:0] scan_reg;         // advertise cell walk, one spare bit for the end
    logic [IW:0] idx_reg;          // tick neighbour walk
    logic        adv_last;

    logic       done_reg;
    logic [1:0] okind_reg;
    logic [7:0] oseq_reg;
    logic [3:0] odest_reg, ocost_reg, ohop_reg;
    logic       ofound_reg, olast_reg;

    assign done = done_reg;
    assign out_kind = okind_reg;
    assign sequence_out = oseq_reg;
    assign dest_out = odest_reg;
    assign cost_out = ocost_reg;
    assign next_hop = ohop_reg;
    assign found = ofound_reg;
    assign last = olast_reg;

    function automatic logic node_ok(input logic [3:0] n);
        return (n != 4'd0) && (n <= NMAX);
    endfunction

    function automatic logic [IW-1:0] nidx(input logic [3:0] n);
        logic [3:0] m;
        m = n - 4'd1;
        return m[IW-1:0];
    endfunction

    // Cell of the route table for a destination row and a hop column.
    function automatic logic [CW-1:0] cidx(input logic [IW-1:0] d, input logic [IW-1:0] h);
        return CW'(int'(d) * NODE_COUNT + int'(h));
    endfunction

    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    // Next nonzero cell at or after the scan pointer, and whether more follow.
    logic [CW:0] adv_hit;
    logic        adv_any;
    logic [3:0]  adv_dest;
    always_comb
    begin
        adv_hit = scan_reg;
        adv_any = 1'b0;
        adv_dest = 4'd0;
        for (int c = CELLS - 1; c >= 0; c--)
        begin
            if (CW'(c) >= scan_reg[CW-1:0] && !scan_reg[CW] && cost_reg[c] != 4'd0)
            begin
                adv_hit = (CW+1)'(c);
                adv_any = 1'b1;
                adv_dest = 4'(c / NODE_COUNT + 1);
            end
        end
        adv_last = 1'b1;
        for (int c = 0; c < CELLS; c++)
        begin
            if ((CW+1)'(c) > adv_hit && cost_reg[c] != 4'd0)
            begin
                adv_last = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (q_valid) state_next = ST_EXEC;
            ST_EXEC:
            begin
                unique case (cur_reg.kind)
                    KIND_TICK:   state_next = ST_TICK;
                    KIND_ADVERT: state_next = ST_ADV;
                    KIND_LOOKUP: state_next = ST_LOOKUP;
                    default:     state_next = ST_IDLE;
                endcase
            end
            ST_TICK:   if (idx_reg == (IW+1)'(NODE_COUNT - 1)) state_next = ST_IDLE;
            ST_ADV:    if (!adv_any || adv_last) state_next = ST_IDLE;
            ST_LOOKUP: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    logic [3:0] lk_hop;
    always_comb
    begin
        lk_hop = 4'd0;
        if (node_ok(cur_reg.node_id))
        begin
            for (int k = NODE_COUNT - 1; k >= 0; k--)
            begin
                if (cost_reg[cidx(nidx(cur_reg.node_id), IW'(k))] != 4'd0)
                begin
                    lk_hop = 4'(k + 1);
                end
            end
        end
    end

    logic [4:0] c1;
    logic [3:0] ecost;
    always_comb
    begin
        c1 = {1'b0, cur_reg.entry_cost} + 5'd1;
        ecost = c1[4] ? COST_MAX : c1[3:0];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid)
        begin
            cur_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            own_seq_reg <= 8'd1;
            hdr_ok_reg <= 1'b0;
            hdr_snd_reg <= 4'd0;
            scan_reg <= '0;
            idx_reg <= '0;
            done_reg <= 1'b0;
            okind_reg <= OUT_BEACON;
            oseq_reg <= 8'd0;
            odest_reg <= 4'd0;
            ocost_reg <= 4'd0;
            ohop_reg <= 4'd0;
            ofound_reg <= 1'b0;
            olast_reg <= 1'b0;
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                live_reg[i] <= 4'd0;
                seen_reg[i] <= 8'd0;
            end
            for (int c = 0; c < CELLS; c++)
            begin
                cost_reg[c] <= 4'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= 1'b0;
            okind_reg <= OUT_BEACON;
            oseq_reg <= 8'd0;
            odest_reg <= 4'd0;
            ocost_reg <= 4'd0;
            ohop_reg <= 4'd0;
            ofound_reg <= 1'b0;
            olast_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    // Both walks start from zero for the next request.
                    scan_reg <= '0;
                    idx_reg <= '0;
                end
                ST_EXEC:
                begin
                    if (cur_reg.kind != KIND_ENTRY)
                    begin
                        hdr_ok_reg <= 1'b0;
                    end
                    case (cur_reg.kind)
                        KIND_BEACON:
                        begin
                            if (node_ok(cur_reg.node_id) && cur_reg.node_id != own_node
                                && cur_reg.strength_ok
                                && cur_reg.sequence_req > seen_reg[nidx(cur_reg.node_id)]
                                && live_reg[nidx(cur_reg.node_id)] == 4'd0)
                            begin
                                live_reg[nidx(cur_reg.node_id)] <= reload;
                                seen_reg[nidx(cur_reg.node_id)] <= cur_reg.sequence_req;
                                cost_reg[cidx(nidx(cur_reg.node_id), nidx(cur_reg.node_id))]
                                    <= 4'd1;
                            end
                        end
                        KIND_HEADER:
                        begin
                            if (node_ok(cur_reg.node_id) && cur_reg.node_id != own_node
                                && cur_reg.strength_ok
                                && cur_reg.sequence_req > seen_reg[nidx(cur_reg.node_id)])
                            begin
                                seen_reg[nidx(cur_reg.node_id)] <= cur_reg.sequence_req;
                                hdr_ok_reg <= 1'b1;
                                hdr_snd_reg <= cur_reg.node_id;
                            end
                        end
                        KIND_ENTRY:
                        begin
                            if (hdr_ok_reg && node_ok(hdr_snd_reg)
                                && node_ok(cur_reg.entry_dest)
                                && cur_reg.entry_dest != own_node)
                            begin : entry_blk
                                logic any, hit;
                                any = 1'b0;
                                hit = 1'b0;
                                for (int h = 0; h < NODE_COUNT; h++)
                                begin
                                    if (!hit && cost_reg[cidx(nidx(cur_reg.entry_dest),
                                        IW'(h))] != 4'd0)
                                    begin
                                        any = 1'b1;
                                        if (ecost < cost_reg[cidx(nidx(cur_reg.entry_dest),
                                            IW'(h))])
                                        begin
                                            hit = 1'b1;
                                            cost_reg[cidx(nidx(cur_reg.entry_dest), IW'(h))]
                                                <= 4'd0;
                                        end
                                    end
                                end
                                // The sender's cell is written last so it wins.
                                if (hit || !any)
                                begin
                                    cost_reg[cidx(nidx(cur_reg.entry_dest),
                                        nidx(hdr_snd_reg))] <= ecost;
                                end
                            end
                        end
                        KIND_TICK:
                        begin
                            done_reg <= 1'b1;
                            okind_reg <= OUT_BEACON;
                            oseq_reg <= own_seq_reg;
                            olast_reg <= 1'b1;
                            own_seq_reg <= own_seq_reg + 8'd1;
                        end
                        KIND_ADVERT:
                        begin
                            done_reg <= 1'b1;
                            okind_reg <= OUT_HEADER;
                            oseq_reg <= own_seq_reg;
                            olast_reg <= !adv_any;
                            own_seq_reg <= own_seq_reg + 8'd1;
                        end
                        default: ;
                    endcase
                end
                ST_TICK:
                begin : tick_blk
                    logic [IW-1:0] i;
                    i = idx_reg[IW-1:0];
                    idx_reg <= idx_reg + 1'b1;
                    if ((4'(idx_reg) + 4'd1) != own_node && live_reg[i] != 4'd0)
                    begin
                        live_reg[i] <= live_reg[i] - 4'd1;
                        if (live_reg[i] == 4'd1)
                        begin
                            for (int k = 0; k < NODE_COUNT; k++)
                            begin
                                cost_reg[cidx(i, IW'(k))] <= 4'd0;
                                cost_reg[cidx(IW'(k), i)] <= 4'd0;
                            end
                        end
                    end
                end
                ST_ADV:
                begin
                    if (adv_any)
                    begin
                        done_reg <= 1'b1;
                        okind_reg <= OUT_ENTRY;
                        odest_reg <= adv_dest;
                        ocost_reg <= cost_reg[adv_hit[CW-1:0]];
                        olast_reg <= adv_last;
                        scan_reg <= adv_hit + 1'b1;
                    end
                end
                ST_LOOKUP:
                begin
                    done_reg <= 1'b1;
                    okind_reg <= OUT_LOOKUP;
                    ohop_reg <= lk_hop;
                    ofound_reg <= (lk_hop != 4'd0);
                    olast_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule

// ----- sv/dvrt_checker.sv -----
// Port-level checks for the route table, bound to the top level.
// Depends on dvrt_pkg and distance_vector_route_table.
module dvrt_checker
    import dvrt_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       done,
    input logic [1:0] out_kind,
    input logic [7:0] sequence_out,
    input logic [3:0] dest_out,
    input logic [3:0] cost_out,
    input logic [3:0] next_hop,
    input logic       found,
    input logic       last
);
    a_found_hop: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (found == (next_hop != 4'd0)))
        else $error("found disagrees with next_hop");
    a_entry_cost: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_kind == OUT_ENTRY) |-> (cost_out != 4'd0 && dest_out != 4'd0))
        else $error("advertised entry with no route");
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (out_kind == OUT_BEACON || out_kind == OUT_LOOKUP)) |-> last)
        else $error("single result not marked last");
    a_after_header: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_kind == OUT_HEADER && !last) |=> (done && out_kind == OUT_ENTRY))
        else $error("header not followed by entry");
    // Only beacons and advert headers carry a sequence number.
    a_no_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (out_kind == OUT_ENTRY || out_kind == OUT_LOOKUP)) |-> (sequence_out == 8'd0))
        else $error("sequence number on an entry or lookup answer");
endmodule

bind distance_vector_route_table dvrt_checker u_checker (
    .clk, .rst_n, .done, .out_kind, .sequence_out, .dest_out, .cost_out,
    .next_hop, .found, .last
);
